FILE: hdl/fppc8_pkg.sv
// ----------------------------------------------------------------------------
// fppc8_pkg: shared types and constants of the framed packet parser
// Byte widths, configuration register indexes, the CRC8 step function and
// the control bundle for the payload buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fppc8_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 8'd1;

    // Register reset values
    localparam logic [BYTE_W-1:0] MAGIC_RESET       = 8'h00;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'hFF;

    // CRC8: polynomial x^8 + x^5 + x^4 + 1, MSB first
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

    // Item kinds
    localparam logic KIND_RX   = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Buffer port enables
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ram_ctl;

    // Fold one byte into the running CRC
    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] acc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] v;
        v = acc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (v[BYTE_W-1]) begin
                v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[BYTE_W-2:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/fppc8_if.sv
// ----------------------------------------------------------------------------
// fppc8_if: channel interfaces of the framed packet parser
// Input item channel, result channel and configuration write channel, each
// with valid/ready and its payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fppc8_in_if;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [fppc8_pkg::BYTE_W-1:0] rx_byte;
    logic [fppc8_pkg::BYTE_W-1:0] read_index;

    modport source (output valid, output kind, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input kind, input rx_byte, input read_index,
                    output ready);
endinterface

interface fppc8_out_if;
    logic                     valid;
    logic                     ready;
    logic                     frame_ok;
    logic [fppc8_pkg::BYTE_W-1:0] frame_type;
    logic [fppc8_pkg::BYTE_W-1:0] frame_length;
    logic [fppc8_pkg::BYTE_W-1:0] read_data;

    modport source (output valid, output frame_ok, output frame_type,
                    output frame_length, output read_data, input ready);
    modport sink   (input valid, input frame_ok, input frame_type,
                    input frame_length, input read_data, output ready);
endinterface

interface fppc8_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [fppc8_pkg::CFG_IDX_W-1:0] index;
    logic [fppc8_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/framed_packet_parser_crc8_unit.sv
// ----------------------------------------------------------------------------
// framed_packet_parser_crc8_unit: byte-serial frame parser with CRC8 check
// Hunts for the magic byte, checks the length, buffers the payload and
// flags frames whose CRC8 over type and payload matches the trailer byte.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one item per transfer; kind 0 carries a received link byte,
//            kind 1 reads the payload buffer at read_index.
//   o_out  : exactly one result per input item, in order. A received byte
//            that closes a frame with a good CRC reports frame_ok with the
//            frame's type and length; a read item returns the stored byte
//            (zero when read_index is beyond the buffer).
//   i_cfg  : register writes (0 = magic byte, 1 = max payload); other
//            indexes are accepted and dropped. Always ready.
// Result valid rises in the cycle after the input transfer. Unless a result
// stalls, one item is taken per cycle: parser state updates in the transfer
// cycle and the buffer read is a single synchronous port, so results stream
// back to back. A stalled result holds in the output register and stops
// input transfers until it is taken. Reset returns the parser to hunting
// and loads register defaults; buffer contents are undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module framed_packet_parser_crc8_unit #(
    parameter int unsigned PAYLOAD_DEPTH = 256
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    fppc8_in_if.sink     i_in,
    fppc8_out_if.source  o_out,
    fppc8_cfg_if.sink    i_cfg
);
    import fppc8_pkg::*;

    localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam logic [BYTE_W:0] DEPTH_LIM = (BYTE_W+1)'(PAYLOAD_DEPTH);

    // Parser phases
    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRC  = 3'd4;

    logic [BYTE_W-1:0] r_magic;
    logic [BYTE_W-1:0] r_max_len;

    logic [2:0]        r_phase,  n_phase;
    logic [BYTE_W-1:0] r_len,    n_len;
    logic [BYTE_W-1:0] r_type,   n_type;
    logic [BYTE_W-1:0] r_crc,    n_crc;
    logic [BYTE_W-1:0] r_cnt,    n_cnt;

    logic              r_s1_valid;
    logic              r_s1_kind;
    logic              r_s1_rd_inr;
    logic              r_s1_ok,   n_ok;
    logic [BYTE_W-1:0] r_s1_type;
    logic [BYTE_W-1:0] r_s1_len;

    logic              in_xfer;
    logic              rx_xfer;
    logic [BYTE_W-1:0] cnt_inc;
    logic [BYTE_W-1:0] crc_step;
    logic [BYTE_W-1:0] rd_data;
    t_ram_ctl          ram_ctl;

    // Take input when the output register is empty or draining
    assign i_in.ready = !r_s1_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign rx_xfer    = in_xfer && (i_in.kind == KIND_RX);

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= MAGIC_RESET;
            r_max_len <= MAX_PAYLOAD_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MAGIC:       r_magic   <= i_cfg.data;
                REG_MAX_PAYLOAD: r_max_len <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Parser next state
    assign cnt_inc  = r_cnt + 8'd1;
    assign crc_step = crc8_update(r_crc, i_in.rx_byte);

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_type  = r_type;
        n_crc   = r_crc;
        n_cnt   = r_cnt;
        n_ok    = 1'b0;
        case (r_phase)
            PH_HUNT: begin
                if (i_in.rx_byte == r_magic) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_len = i_in.rx_byte;
                if (i_in.rx_byte > r_max_len) begin
                    n_phase = PH_HUNT;
                end else begin
                    n_cnt   = '0;
                    n_crc   = '0;
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_type  = i_in.rx_byte;
                n_crc   = crc8_update('0, i_in.rx_byte);
                n_phase = (r_len == '0) ? PH_CRC : PH_DATA;
            end
            PH_DATA: begin
                n_cnt = cnt_inc;
                n_crc = crc_step;
                if (cnt_inc >= r_len) begin
                    n_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                n_phase = PH_HUNT;
                n_ok    = (i_in.rx_byte == r_crc);
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // Advance the parser on received bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= '0;
            r_type  <= '0;
            r_crc   <= '0;
            r_cnt   <= '0;
        end else if (rx_xfer) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_type  <= n_type;
            r_crc   <= n_crc;
            r_cnt   <= n_cnt;
        end
    end

    // Buffer: store payload bytes in range, read on read items
    assign ram_ctl.wr_en = rx_xfer && (r_phase == PH_DATA) && ({1'b0, r_cnt} < DEPTH_LIM);
    assign ram_ctl.rd_en = in_xfer && (i_in.kind == KIND_READ);

    fppc8_payload_ram #(
        .DEPTH (PAYLOAD_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_ctl     (ram_ctl),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (i_in.rx_byte),
        .i_rd_addr (i_in.read_index[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Output register: valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    // Output register: payload, hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_kind   <= i_in.kind;
            r_s1_rd_inr <= ({1'b0, i_in.read_index} < DEPTH_LIM);
            r_s1_ok     <= rx_xfer && n_ok;
            r_s1_type   <= (rx_xfer && n_ok) ? r_type : '0;
            r_s1_len    <= (rx_xfer && n_ok) ? r_len  : '0;
        end
    end

    assign o_out.valid        = r_s1_valid;
    assign o_out.frame_ok     = r_s1_ok;
    assign o_out.frame_type   = r_s1_type;
    assign o_out.frame_length = r_s1_len;
    assign o_out.read_data    = (r_s1_kind == KIND_READ && r_s1_rd_inr) ? rd_data : '0;

`ifndef SYNTH
    // A good trailer byte must produce a frame_ok result
    a_crc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_xfer && (r_phase == PH_CRC) && (i_in.rx_byte == r_crc) |=> r_s1_ok)
        else $error("matching CRC did not flag frame_ok");

    // A read item never reports a frame
    a_read_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in.kind == KIND_READ) |=> !r_s1_ok && (r_s1_len == '0))
        else $error("read item reported a frame");

    // Payload count stays below the frame length while collecting payload
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_cnt < r_len))
        else $error("payload count reached length in payload phase");

    // A stalled result blocks new input transfers
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !o_out.ready |-> !i_in.ready)
        else $error("input accepted over a stalled result");
`endif

endmodule

`default_nettype wire

FILE: hdl/fppc8_payload_ram.sv
// ----------------------------------------------------------------------------
// fppc8_payload_ram: payload byte buffer
// Single write port and single read port, read data registered and held
// while the read enable is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fppc8_payload_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  wire logic                           i_clk,
    input  wire fppc8_pkg::t_ram_ctl            i_ctl,
    input  wire logic [AW-1:0]                  i_wr_addr,
    input  wire logic [fppc8_pkg::BYTE_W-1:0]   i_wr_data,
    input  wire logic [AW-1:0]                  i_rd_addr,
    output logic      [fppc8_pkg::BYTE_W-1:0]   o_rd_data
);
    import fppc8_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
